>>> rtl/brct_pkg.sv
// Package with the types and constants shared by the buffer range conflict table.
`default_nettype none
package brct_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int ADDR_BITS_DEF   = 48;
  localparam int TAG_W           = 16;
  localparam int BASE_W          = 48;
  localparam int COUNT_W         = 31;
  localparam int SIZE_W          = 16;
  localparam int PROD_W          = COUNT_W + SIZE_W;

  localparam logic REQ_REGISTER = 1'b0;
  localparam logic REQ_RELEASE  = 1'b1;

  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_CONFLICT = 3'd1,
    ST_FULL     = 3'd2,
    ST_IGNORED  = 3'd3,
    ST_RELEASED = 3'd4,
    ST_UNKNOWN  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEN,
    S_SCAN,
    S_DECIDE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic               req_type;
    logic [TAG_W-1:0]   request_id;
    logic [BASE_W-1:0]  base_addr;
    logic [COUNT_W-1:0] element_count;
    logic [SIZE_W-1:0]  element_size;
    logic               write_flag;
  } in_t;

  typedef struct packed {
    status_t          status;
    logic [TAG_W-1:0] conflict_id;
  } out_t;

endpackage
`default_nettype wire

>>> rtl/brct_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module brct_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> rtl/buffer_range_conflict_table.sv
// Buffer range conflict table: tracks byte regions of in-flight transfers by request tag.
//
// Input channel in_valid/in_ready/in_data carries register and release requests; the
// output channel out_valid/out_ready/out_data returns one status per request. The
// configuration port (cfg_wr_en, cfg_wr_data) sets the enable bit at any clock edge.
// A register request is checked against every entry; a release frees a tag's entry.
// Entries live in one RAM with a registered read; valid bits are flip-flops.
// A request that is acted on passes through S_LEN, S_SCAN and S_DECIDE to S_RESP, where
// its result enters the output register; an ignored request (disabled or tag zero) goes
// straight to S_RESP. The scan reads one RAM entry per cycle. A request is taken only in
// S_IDLE, so one request is in progress at a time.
// A new request is taken while an earlier result still waits in the output register.
// If the receiver stalls, the next result is held until that register is free.
// Synchronous reset clears all valid bits together, so no clearing pass is needed;
// the enable bit resets to zero.
`default_nettype none
module buffer_range_conflict_table import brct_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data,
  input  wire logic cfg_wr_en,
  input  wire logic cfg_wr_data
);

  localparam int IW  = $clog2(TABLE_DEPTH);
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int EW  = ADDR_BITS + 1;
  localparam int XW  = (PROD_W > ADDR_BITS) ? PROD_W : ADDR_BITS;
  localparam int BXW = (BASE_W > ADDR_BITS) ? BASE_W : ADDR_BITS;
  localparam int RW  = TAG_W + ADDR_BITS + EW + 1;

  state_t state_r, state_nxt;
  logic   enabled_r;
  logic [TABLE_DEPTH-1:0] valid_r;

  logic                 kind_r;
  logic [TAG_W-1:0]     tag_r;
  logic [ADDR_BITS-1:0] base_r;
  logic                 wr_r;
  logic [PROD_W-1:0]    prod_r;
  logic [EW-1:0]        req_end_r;

  logic [CW-1:0] scan_r;
  logic          cmp_vld_r;
  logic [IW-1:0] cmp_idx_r;

  logic             conflict_r;
  logic [TAG_W-1:0] hit_tag_r;
  logic             match_found_r;
  logic [IW-1:0]    match_idx_r;
  logic             free_found_r;
  logic [IW-1:0]    free_idx_r;

  status_t          res_status_r, res_status_nxt;
  logic [TAG_W-1:0] res_id_r, res_id_nxt;

  logic out_valid_r;
  out_t out_data_r;

  logic          accept;
  logic          ignore_req;
  logic          scan_end;
  logic          out_load;
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [IW-1:0] ram_raddr;
  logic [RW-1:0] ram_wdata;
  logic [RW-1:0] ram_rdata;
  logic          valid_set;
  logic          valid_clr;

  logic [BXW-1:0]       base_x;
  logic [XW-1:0]        prod_x;
  logic [ADDR_BITS-1:0] len;

  logic [TAG_W-1:0]     ent_tag;
  logic [ADDR_BITS-1:0] ent_base;
  logic [EW-1:0]        ent_end;
  logic                 ent_wr;
  logic                 ent_live;
  logic                 ent_hit;
  logic                 ent_tag_hit;
  logic                 ent_free;

  assign accept     = in_valid && in_ready;
  assign ignore_req = !enabled_r || (in_data.request_id == '0);
  assign scan_end   = (scan_r == CW'(TABLE_DEPTH));
  assign base_x     = BXW'(in_data.base_addr);
  assign prod_x     = XW'(prod_r);
  assign len        = (prod_x > XW'({ADDR_BITS{1'b1}})) ? {ADDR_BITS{1'b1}}
                                                        : prod_x[ADDR_BITS-1:0];

  assign ent_tag     = ram_rdata[RW-1 -: TAG_W];
  assign ent_base    = ram_rdata[EW+1 +: ADDR_BITS];
  assign ent_end     = ram_rdata[1 +: EW];
  assign ent_wr      = ram_rdata[0];
  assign ent_live    = cmp_vld_r && valid_r[cmp_idx_r];
  assign ent_hit     = ent_live && ({1'b0, ent_base} < req_end_r)
                       && ({1'b0, base_r} < ent_end) && (wr_r || ent_wr);
  assign ent_tag_hit = ent_live && (ent_tag == tag_r);
  assign ent_free    = cmp_vld_r && !valid_r[cmp_idx_r];

  brct_ram #(
    .WIDTH(RW),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = ignore_req ? S_RESP : S_LEN;
        end
      end
      S_LEN: begin
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (scan_end) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    out_load       = 1'b0;
    ram_we         = 1'b0;
    valid_set      = 1'b0;
    valid_clr      = 1'b0;
    ram_waddr      = match_found_r ? match_idx_r : free_idx_r;
    ram_wdata      = {tag_r, base_r, req_end_r, wr_r};
    ram_raddr      = scan_end ? '0 : scan_r[IW-1:0];
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (accept && ignore_req) begin
          res_status_nxt = ST_IGNORED;
          res_id_nxt     = '0;
        end
      end
      S_LEN, S_SCAN: begin
      end
      S_DECIDE: begin
        res_id_nxt = '0;
        if (kind_r == REQ_RELEASE) begin
          if (match_found_r) begin
            valid_clr      = 1'b1;
            res_status_nxt = ST_RELEASED;
          end else begin
            res_status_nxt = ST_UNKNOWN;
          end
        end else if (conflict_r) begin
          res_status_nxt = ST_CONFLICT;
          res_id_nxt     = hit_tag_r;
        end else if (match_found_r || free_found_r) begin
          ram_we         = 1'b1;
          valid_set      = 1'b1;
          res_status_nxt = ST_STORED;
        end else begin
          res_status_nxt = ST_FULL;
        end
      end
      S_RESP: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      enabled_r   <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      scan_r      <= '0;
      cmp_vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        enabled_r <= cfg_wr_data;
      end
      if (valid_set) begin
        valid_r[ram_waddr] <= 1'b1;
      end
      if (valid_clr) begin
        valid_r[match_idx_r] <= 1'b0;
      end
      out_valid_r <= out_load || (out_valid_r && !out_ready);
      if (state_r == S_LEN) begin
        scan_r <= '0;
      end else if (state_r == S_SCAN && !scan_end) begin
        scan_r <= scan_r + CW'(1);
      end
      cmp_vld_r <= (state_r == S_SCAN) && !scan_end;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r    <= ram_raddr;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    if (out_load) begin
      out_data_r.status      <= res_status_r;
      out_data_r.conflict_id <= res_id_r;
    end
    if (accept) begin
      kind_r <= in_data.req_type;
      tag_r  <= in_data.request_id;
      base_r <= base_x[ADDR_BITS-1:0];
      wr_r   <= in_data.write_flag;
      prod_r <= PROD_W'(in_data.element_count) * PROD_W'(in_data.element_size);
    end
    if (state_r == S_LEN) begin
      req_end_r     <= {1'b0, base_r} + {1'b0, len};
      conflict_r    <= 1'b0;
      hit_tag_r     <= '0;
      match_found_r <= 1'b0;
      match_idx_r   <= '0;
      free_found_r  <= 1'b0;
      free_idx_r    <= '0;
    end else begin
      if (ent_hit && !conflict_r) begin
        conflict_r <= 1'b1;
        hit_tag_r  <= ent_tag;
      end
      if (ent_tag_hit && !match_found_r) begin
        match_found_r <= 1'b1;
        match_idx_r   <= cmp_idx_r;
      end
      if (ent_free && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= cmp_idx_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_store_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> valid_r[$past(ram_waddr)])
    else $error("stored entry not marked valid");

  a_conflict_has_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_CONFLICT) |-> out_data.conflict_id != '0)
    else $error("conflict reported without a tag");

  a_no_tag_otherwise: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_CONFLICT) |-> out_data.conflict_id == '0)
    else $error("tag reported without a conflict");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in progress");

endmodule
`default_nettype wire
